### sv/dfrm_pkg.sv
// ----------------------------------------------------------------------------
// dfrm_pkg
// Shared widths, status codes and the per-item command passed from the
// snapshot controller to the delta evaluation stage.
// ----------------------------------------------------------------------------
package dfrm_pkg;

  localparam int FREQ_W        = 24;
  localparam int TICK_W        = 64;
  localparam int MAX_STEPS_DEF = 64;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_VALID     = 2'd0,
    STATUS_BASELINE  = 2'd1,
    STATUS_NO_CHANGE = 2'd2,
    STATUS_OVERFLOW  = 2'd3
  } status_t;

  // per-item command; on a last item, STATUS_VALID means the final code
  // still depends on the largest delta
  typedef struct packed {
    logic    in_range;
    logic    last;
    status_t status;
    logic    base_b;
  } cmd_t;

endpackage

### sv/dfrm_ram.sv
// ----------------------------------------------------------------------------
// dfrm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dfrm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/dfrm_ctrl.sv
// ----------------------------------------------------------------------------
// dfrm_ctrl
// Snapshot controller: entry index, overflow flag, bank roles and baseline
// bookkeeping, all settled at the cycle an item is accepted.
// ----------------------------------------------------------------------------
module dfrm_ctrl #(
  parameter int MAX_STEPS = dfrm_pkg::MAX_STEPS_DEF,
  localparam int AW       = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1,
  localparam int IW       = $clog2(MAX_STEPS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                last_entry,
  output dfrm_pkg::cmd_t      cmd,
  output logic                we_a,
  output logic                we_b,
  output logic                re,
  output logic [AW-1:0]       addr
);

  logic [IW-1:0] idx;
  logic [IW-1:0] idx_next;
  logic          ovf;
  logic          ovf_next;
  logic          bank_sel;
  logic          bank_sel_next;
  logic          have_base;
  logic          have_base_next;
  logic [IW-1:0] stored_count;
  logic [IW-1:0] stored_count_next;

  logic          in_range;
  logic [IW-1:0] count_after;
  logic          ovf_after;
  dfrm_pkg::status_t cls;

  // position of this item in the snapshot
  assign in_range    = (idx < IW'(MAX_STEPS));
  assign count_after = in_range ? idx + IW'(1) : idx;
  assign ovf_after   = ovf | ~in_range;

  // end-of-snapshot classification
  always_comb begin
    if (ovf_after) begin
      cls = dfrm_pkg::STATUS_OVERFLOW;
    end else if (!have_base || (stored_count != count_after)) begin
      cls = dfrm_pkg::STATUS_BASELINE;
    end else begin
      cls = dfrm_pkg::STATUS_VALID;
    end
  end

  assign cmd.in_range = in_range;
  assign cmd.last     = last_entry;
  assign cmd.status   = cls;
  assign cmd.base_b   = bank_sel;

  // bank 1 holds the baseline when bank_sel is set, so the other one fills
  assign addr = idx[AW-1:0];
  assign re   = accept & in_range;
  assign we_a = accept & in_range & bank_sel;
  assign we_b = accept & in_range & ~bank_sel;

  // next state
  always_comb begin
    idx_next          = idx;
    ovf_next          = ovf;
    bank_sel_next     = bank_sel;
    have_base_next    = have_base;
    stored_count_next = stored_count;
    if (accept) begin
      if (last_entry) begin
        idx_next = '0;
        ovf_next = 1'b0;
        if (cls != dfrm_pkg::STATUS_OVERFLOW) begin
          bank_sel_next = ~bank_sel;
        end
        if (cls == dfrm_pkg::STATUS_BASELINE) begin
          have_base_next    = 1'b1;
          stored_count_next = count_after;
        end
      end else begin
        idx_next = count_after;
        ovf_next = ovf_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= '0;
      ovf          <= 1'b0;
      bank_sel     <= 1'b0;
      have_base    <= 1'b0;
      stored_count <= '0;
    end else begin
      idx          <= idx_next;
      ovf          <= ovf_next;
      bank_sel     <= bank_sel_next;
      have_base    <= have_base_next;
      stored_count <= stored_count_next;
    end
  end

  // index never passes the bank depth
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    idx <= IW'(MAX_STEPS))
    else $error("entry index beyond bank depth");

  // a last item restarts the snapshot
  a_snap_restart: assert property (@(posedge clk) disable iff (rst)
    accept && last_entry |=> (idx == '0) && !ovf)
    else $error("snapshot state not cleared after last item");

  // no stored count without a baseline
  a_count_base: assert property (@(posedge clk) disable iff (rst)
    !have_base |-> (stored_count == '0))
    else $error("stored count set without baseline");

  // bank roles swap only at a last item
  a_swap_last: assert property (@(posedge clk) disable iff (rst)
    (bank_sel != $past(bank_sel)) |-> $past(accept && last_entry))
    else $error("bank swap outside snapshot end");

endmodule

### sv/dfrm_eval.sv
// ----------------------------------------------------------------------------
// dfrm_eval
// Delta stage: forms the tick delta against the baseline, tracks the first
// largest delta and registers the result of each snapshot.
// ----------------------------------------------------------------------------
module dfrm_eval (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  dfrm_pkg::cmd_t                 cmd,
  input  logic [dfrm_pkg::FREQ_W-1:0]    entry_freq,
  input  logic [dfrm_pkg::TICK_W-1:0]    residency_ticks,
  input  logic [dfrm_pkg::TICK_W-1:0]    prev_a,
  input  logic [dfrm_pkg::TICK_W-1:0]    prev_b,
  output logic                           out_valid,
  input  logic                           out_ready,
  output dfrm_pkg::status_t              status,
  output logic [dfrm_pkg::FREQ_W-1:0]    dominant_freq
);

  logic                          s1_valid;
  dfrm_pkg::cmd_t                s1_cmd;
  logic [dfrm_pkg::FREQ_W-1:0]   s1_freq;
  logic [dfrm_pkg::TICK_W-1:0]   s1_ticks;
  logic [dfrm_pkg::TICK_W-1:0]   top_delta;
  logic [dfrm_pkg::FREQ_W-1:0]   best_freq;

  logic [dfrm_pkg::TICK_W-1:0]   prev;
  logic [dfrm_pkg::TICK_W-1:0]   delta;
  logic                          take;
  logic [dfrm_pkg::TICK_W-1:0]   top_delta_next;
  logic [dfrm_pkg::FREQ_W-1:0]   best_freq_next;
  logic                          s1_fire;
  logic                          accept;
  dfrm_pkg::status_t             res_status;
  logic [dfrm_pkg::FREQ_W-1:0]   res_freq;

  // delta against baseline, clamped at zero when the counter went back
  assign prev  = s1_cmd.base_b ? prev_b : prev_a;
  assign delta = (prev <= s1_ticks) ? (s1_ticks - prev) : '0;

  // first maximum wins, so only a strictly larger delta replaces it
  assign take           = s1_cmd.in_range & (delta > top_delta);
  assign top_delta_next = take ? delta : top_delta;
  assign best_freq_next = take ? s1_freq : best_freq;

  // final status and frequency
  always_comb begin
    res_status = s1_cmd.status;
    if (s1_cmd.status == dfrm_pkg::STATUS_VALID && top_delta_next == '0) begin
      res_status = dfrm_pkg::STATUS_NO_CHANGE;
    end
    res_freq = (res_status == dfrm_pkg::STATUS_VALID) ? best_freq_next : '0;
  end

  // stage advance: only a last item needs room in the result register
  assign s1_fire  = s1_valid & (~s1_cmd.last | ~out_valid | out_ready);
  assign in_ready = ~s1_valid | s1_fire;
  assign accept   = in_valid & in_ready;

  // control and tracked maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      top_delta <= '0;
      best_freq <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_fire && s1_cmd.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (s1_fire) begin
        if (s1_cmd.last) begin
          top_delta <= '0;
          best_freq <= '0;
        end else begin
          top_delta <= top_delta_next;
          best_freq <= best_freq_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd   <= cmd;
      s1_freq  <= entry_freq;
      s1_ticks <= residency_ticks;
    end
    if (s1_fire && s1_cmd.last) begin
      status        <= res_status;
      dominant_freq <= res_freq;
    end
  end

  // frequency is reported only with a valid status
  a_freq_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != dfrm_pkg::STATUS_VALID) |-> (dominant_freq == '0))
    else $error("frequency set with non-valid status");

  // tracker cleared after each snapshot
  a_best_clear: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_cmd.last |=> (top_delta == '0) && (best_freq == '0))
    else $error("top delta not cleared at snapshot end");

  // a waiting result holds still until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(dominant_freq))
    else $error("result changed while waiting");

endmodule

### sv/dominant_frequency_residency_monitor_top.sv
// ----------------------------------------------------------------------------
// dominant_frequency_residency_monitor_top
// Per-entry tick deltas against a double-banked baseline; reports the
// frequency with the largest delta at the last entry of each snapshot.
// ----------------------------------------------------------------------------
// a last entry's result passes the s1 register and then the result register
// throughput: one entry per cycle, set by a single bank read and write per entry,
// except while a stalled result holds back a last one; non-last entries flow in
// reset: controller and tracker clear; no baseline, bank 0 holds it
// tick banks are not cleared and need no clearing pass after reset
// ----------------------------------------------------------------------------
module dominant_frequency_residency_monitor_top #(
  parameter int MAX_STEPS = dfrm_pkg::MAX_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dfrm_pkg::FREQ_W-1:0]    entry_freq,
  input  logic [dfrm_pkg::TICK_W-1:0]    residency_ticks,
  input  logic                           last_entry,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     status,
  output logic [dfrm_pkg::FREQ_W-1:0]    dominant_freq
);

  localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  logic                          accept;
  dfrm_pkg::cmd_t                cmd;
  logic                          we_a;
  logic                          we_b;
  logic                          re;
  logic [AW-1:0]                 addr;
  logic [dfrm_pkg::TICK_W-1:0]   prev_a;
  logic [dfrm_pkg::TICK_W-1:0]   prev_b;
  dfrm_pkg::status_t             res_status;

  assign accept = in_valid & in_ready;
  assign status = res_status;

  // snapshot controller
  dfrm_ctrl #(
    .MAX_STEPS (MAX_STEPS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .last_entry (last_entry),
    .cmd        (cmd),
    .we_a       (we_a),
    .we_b       (we_b),
    .re         (re),
    .addr       (addr)
  );

  // tick bank a
  dfrm_ram #(
    .WIDTH (dfrm_pkg::TICK_W),
    .DEPTH (MAX_STEPS)
  ) u_bank_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (addr),
    .wdata (residency_ticks),
    .re    (re),
    .raddr (addr),
    .rdata (prev_a)
  );

  // tick bank b
  dfrm_ram #(
    .WIDTH (dfrm_pkg::TICK_W),
    .DEPTH (MAX_STEPS)
  ) u_bank_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (addr),
    .wdata (residency_ticks),
    .re    (re),
    .raddr (addr),
    .rdata (prev_b)
  );

  // delta evaluation and result register
  dfrm_eval u_eval (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cmd             (cmd),
    .entry_freq      (entry_freq),
    .residency_ticks (residency_ticks),
    .prev_a          (prev_a),
    .prev_b          (prev_b),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (res_status),
    .dominant_freq   (dominant_freq)
  );

endmodule
